FILE: hdl/ded_pkg.sv
// Shared types and constants for the directory entry decoder.
// Depends on nothing; imported by ded_attr and directory_entry_decoder.
`timescale 1ns / 1ps

package ded_pkg;

    // Image layout
    localparam int unsigned OffsetWidth = 11;
    localparam logic [OffsetWidth-1:0] OFFSET_MAX       = 11'd2047;
    localparam logic [OffsetWidth-1:0] ENTRY_BASE       = 11'd5;
    localparam logic [OffsetWidth-1:0] OLD_PARENT_AT    = 11'd1238;
    localparam logic [OffsetWidth-1:0] D_PARENT_AT      = 11'd2010;
    localparam logic [6:0]             OLD_ENTRY_LIMIT  = 7'd47;
    localparam logic [6:0]             D_ENTRY_LIMIT    = 7'd77;
    localparam logic [4:0]             ENTRY_LAST_POS   = 5'd25;
    localparam logic [6:0]             CHAR_CR          = 7'h0d;

    // Type class detection constants
    localparam logic [15:0] EXEC_BASIC_A = 16'h8023;
    localparam logic [15:0] EXEC_BASIC_B = 16'h802B;
    localparam logic [15:0] HALF_ONES    = 16'hFFFF;

    // Result kind, carried on m_tuser
    typedef enum logic {
        KIND_ENTRY   = 1'b0,
        KIND_TRAILER = 1'b1
    } ded_kind_t;

    // Type class codes
    typedef enum logic [2:0] {
        TC_BINARY  = 3'd0,
        TC_BASIC   = 3'd1,
        TC_SPOOL   = 3'd2,
        TC_DATA    = 3'd3,
        TC_GRAPHIC = 3'd4
    } ded_type_t;

    // Result payload as packed on m_tdata, first member in the highest bits
    typedef struct packed {
        logic        pad;
        ded_type_t   type_class;
        logic [4:0]  attributes;
        logic [7:0]  sequence_res;
        logic [23:0] sector_number;
        logic [31:0] file_length;
        logic [31:0] exec_address;
        logic [31:0] load_address;
        logic [15:0] name_high;
        logic [63:0] name_low;
        logic [6:0]  entry_index;
    } ded_result_t;

    // Captured entry words handed to the attribute decoder
    typedef struct packed {
        logic [4:0]  flag_bits;
        logic [7:0]  seq_byte;
        logic [31:0] load_word;
        logic [31:0] exec_word;
        logic [31:0] length_word;
    } ded_fields_t;

endpackage

FILE: hdl/directory_entry_decoder.sv
// Directory entry decoder: byte stream in, decoded entries and trailer out.
// A result is registered: it is on m_tvalid in the cycle after the beat that causes it.
// Throughput: one byte per cycle; s_tready is low only while a held result
// is not taken (single output register, s_tready = !m_tvalid | m_tready).
// Reset (aresetn low, synchronous) clears the offset, entry position, listing
// state, layout select, all field stores and the output valid.
// Depends on ded_pkg and ded_attr.
`timescale 1ns / 1ps

module directory_entry_decoder
    import ded_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic         cfg_wdata,      // d_format

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,        // [7:0] dir_byte
    input  logic         s_tlast,        // last_byte

    output logic         m_tvalid,
    input  logic         m_tready,
    // [6:0] entry_index, [70:7] name_low, [86:71] name_high,
    // [118:87] load_address, [150:119] exec_address, [182:151] file_length,
    // [206:183] sector_number, [214:207] sequence_res, [219:215] attributes,
    // [222:220] type_class, [223] zero
    output logic [223:0] m_tdata,
    output logic         m_tuser         // kind
);

    // Control state
    logic                   d_format_reg;
    logic [OffsetWidth-1:0] offset_reg,  offset_next;
    logic [4:0]             seg_pos_reg, seg_pos_next;
    logic [6:0]             entry_k_reg, entry_k_next;
    logic                   listing_ended_reg, listing_ended_next;
    logic                   m_valid_reg, m_valid_next;

    // Field stores
    logic [63:0] name_reg,   name_next;
    logic [15:0] tail_reg,   tail_next;
    logic [4:0]  flags_reg,  flags_next;
    logic [31:0] load_reg,   load_next;
    logic [31:0] exec_reg,   exec_next;
    logic [31:0] length_reg, length_next;
    logic [23:0] sector_reg, sector_next;
    logic [7:0]  master_reg, master_next;
    logic [23:0] parent_reg, parent_next;

    // Output register
    ded_result_t result_reg, result_next;
    ded_kind_t   kind_reg,   kind_next;

    logic                   accept;
    logic [7:0]             dir_byte;
    logic [6:0]             clean_char;
    logic [6:0]             entry_limit;
    logic [OffsetWidth-1:0] parent_at;
    logic [OffsetWidth-1:0] parent_rel;
    logic                   in_entries;
    logic                   entry_done;
    logic [4:0]             lane_tail, lane_load, lane_exec, lane_length, lane_sector;
    ded_fields_t            entry_fields;
    logic [4:0]             entry_attr;
    ded_type_t              entry_type;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign dir_byte = s_tdata;

    assign entry_limit = d_format_reg ? D_ENTRY_LIMIT : OLD_ENTRY_LIMIT;
    assign parent_at   = d_format_reg ? D_PARENT_AT : OLD_PARENT_AT;
    assign parent_rel  = offset_reg - parent_at;
    assign in_entries  = (offset_reg >= ENTRY_BASE) && (entry_k_reg < entry_limit);
    assign entry_done  = in_entries && (seg_pos_reg == ENTRY_LAST_POS) && !listing_ended_reg;

    // Strip bit 7 and blank out CR
    assign clean_char = (dir_byte[6:0] == CHAR_CR) ? 7'd0 : dir_byte[6:0];

    assign lane_tail   = seg_pos_reg - 5'd8;
    assign lane_load   = seg_pos_reg - 5'd10;
    assign lane_exec   = seg_pos_reg - 5'd14;
    assign lane_length = seg_pos_reg - 5'd18;
    assign lane_sector = seg_pos_reg - 5'd22;

    // Entry words used by the decoder: stores are not written at the last entry byte
    assign entry_fields = '{
        flag_bits:   flags_reg,
        seq_byte:    dir_byte,
        load_word:   load_reg,
        exec_word:   exec_reg,
        length_word: length_reg
    };

    ded_attr u_attr (
        .d_format   (d_format_reg),
        .fields     (entry_fields),
        .attributes (entry_attr),
        .type_class (entry_type)
    );

    // Capture image bytes into the stores
    always_comb begin
        name_next          = name_reg;
        tail_next          = tail_reg;
        flags_next         = flags_reg;
        load_next          = load_reg;
        exec_next          = exec_reg;
        length_next        = length_reg;
        sector_next        = sector_reg;
        master_next        = master_reg;
        parent_next        = parent_reg;
        listing_ended_next = listing_ended_reg;

        if (offset_reg == '0) begin
            master_next = dir_byte;
        end
        if (offset_reg >= parent_at && parent_rel < 11'd3) begin
            parent_next[parent_rel[1:0]*8 +: 8] = dir_byte;
        end

        if (in_entries) begin
            if (seg_pos_reg < 5'd8) begin
                name_next[seg_pos_reg[2:0]*8 +: 8] = {1'b0, clean_char};
            end else if (seg_pos_reg < 5'd10) begin
                tail_next[lane_tail[0]*8 +: 8] = {1'b0, clean_char};
            end else if (seg_pos_reg < 5'd14) begin
                load_next[lane_load[1:0]*8 +: 8] = dir_byte;
            end else if (seg_pos_reg < 5'd18) begin
                exec_next[lane_exec[1:0]*8 +: 8] = dir_byte;
            end else if (seg_pos_reg < 5'd22) begin
                length_next[lane_length[1:0]*8 +: 8] = dir_byte;
            end else if (seg_pos_reg < 5'd25) begin
                sector_next[lane_sector[1:0]*8 +: 8] = dir_byte;
            end
            if (seg_pos_reg < 5'd5) begin
                flags_next[seg_pos_reg[2:0]] = dir_byte[7];
            end
            if (seg_pos_reg == 5'd0 && dir_byte == 8'd0) begin
                listing_ended_next = 1'b1;
            end
        end

        if (s_tlast) begin
            listing_ended_next = 1'b0;
        end
    end

    // Advance the offset and the entry position; restart on the last beat
    always_comb begin
        offset_next  = offset_reg;
        seg_pos_next = seg_pos_reg;
        entry_k_next = entry_k_reg;
        if (s_tlast) begin
            offset_next  = '0;
            seg_pos_next = '0;
            entry_k_next = '0;
        end else if (offset_reg != OFFSET_MAX) begin
            offset_next = offset_reg + 11'd1;
            if (offset_reg >= ENTRY_BASE) begin
                if (seg_pos_reg == ENTRY_LAST_POS) begin
                    seg_pos_next = '0;
                    entry_k_next = entry_k_reg + 7'd1;
                end else begin
                    seg_pos_next = seg_pos_reg + 5'd1;
                end
            end
        end
    end

    // Build the result: trailer wins over an entry finishing on the last beat
    always_comb begin
        result_next  = result_reg;
        kind_next    = kind_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (accept && s_tlast) begin
            result_next               = '0;
            result_next.sector_number = parent_next;
            result_next.sequence_res  = master_next;
            kind_next                 = KIND_TRAILER;
            m_valid_next              = 1'b1;
        end else if (accept && entry_done) begin
            result_next.pad           = 1'b0;
            result_next.type_class    = entry_type;
            result_next.attributes    = entry_attr;
            result_next.sequence_res  = dir_byte;
            result_next.sector_number = sector_reg;
            result_next.file_length   = length_reg;
            result_next.exec_address  = exec_reg;
            result_next.load_address  = load_reg;
            result_next.name_high     = tail_reg;
            result_next.name_low      = name_reg;
            result_next.entry_index   = entry_k_reg;
            kind_next                 = KIND_ENTRY;
            m_valid_next              = 1'b1;
        end
    end

    // Hold state and stores; update them on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_format_reg      <= 1'b0;
            offset_reg        <= '0;
            seg_pos_reg       <= '0;
            entry_k_reg       <= '0;
            listing_ended_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
            name_reg          <= '0;
            tail_reg          <= '0;
            flags_reg         <= '0;
            load_reg          <= '0;
            exec_reg          <= '0;
            length_reg        <= '0;
            sector_reg        <= '0;
            master_reg        <= '0;
            parent_reg        <= '0;
        end else begin
            if (cfg_we) begin
                d_format_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
            if (accept) begin
                offset_reg        <= offset_next;
                seg_pos_reg       <= seg_pos_next;
                entry_k_reg       <= entry_k_next;
                listing_ended_reg <= listing_ended_next;
                name_reg          <= name_next;
                tail_reg          <= tail_next;
                flags_reg         <= flags_next;
                load_reg          <= load_next;
                exec_reg          <= exec_next;
                length_reg        <= length_next;
                sector_reg        <= sector_next;
                master_reg        <= master_next;
                parent_reg        <= parent_next;
            end
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        kind_reg   <= kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;
    assign m_tuser  = kind_reg;

    // Entry position stays within one 26-byte entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        seg_pos_reg <= ENTRY_LAST_POS)
        else $error("entry byte position out of range");

    // Before the first entry the position counters are idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        offset_reg < ENTRY_BASE |-> seg_pos_reg == 5'd0 && entry_k_reg == 7'd0)
        else $error("entry position moved before first entry");

    // The last beat restarts the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> offset_reg == '0 && !listing_ended_reg && m_tvalid
            && m_tuser == KIND_TRAILER)
        else $error("last beat did not restart the image");

    // An entry index always stays below the D layout limit, the larger of the two limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ENTRY |-> m_tdata[6:0] < D_ENTRY_LIMIT)
        else $error("entry index beyond limit");

    // A new result is only loaded when the held one is gone
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !accept)
        else $error("beat accepted over a held result");

endmodule

FILE: hdl/ded_attr.sv
// Attribute and type class decode for one finished directory entry.
// Depends on ded_pkg for the field struct and type class codes.
`timescale 1ns / 1ps

module ded_attr
    import ded_pkg::*;
(
    input  logic        d_format,
    input  ded_fields_t fields,
    output logic [4:0]  attributes,
    output ded_type_t   type_class
);

    logic [15:0] load_lo;
    logic [15:0] exec_lo;
    logic        graphic_hit;

    assign load_lo = fields.load_word[15:0];
    assign exec_lo = fields.exec_word[15:0];

    // Attributes: name top bits in the old layout (only bits 4:3 kept when bit 4 is set), sequence byte low nibble in D
    always_comb begin
        if (d_format) begin
            attributes = {1'b0, fields.seq_byte[3:0]};
        end else if (fields.flag_bits[4]) begin
            attributes = fields.flag_bits & 5'b11000;
        end else begin
            attributes = fields.flag_bits;
        end
    end

    // Known screen load address and length pairs
    assign graphic_hit =
        (fields.length_word == 32'h0000_5000 && load_lo == 16'h3000) ||
        (fields.length_word == 32'h0000_4000 && load_lo == 16'h4000) ||
        (fields.length_word == 32'h0000_2800 && load_lo == 16'h5800) ||
        (fields.length_word == 32'h0000_6000 && load_lo == 16'h2000) ||
        (fields.length_word == 32'h0000_0400 && load_lo == 16'h7C00);

    // Later tests take priority over earlier ones
    always_comb begin
        type_class = TC_BINARY;
        if (exec_lo == EXEC_BASIC_A || exec_lo == EXEC_BASIC_B) begin
            type_class = TC_BASIC;
        end
        if (exec_lo == HALF_ONES && load_lo == 16'h0000) begin
            type_class = TC_SPOOL;
        end
        if (exec_lo == HALF_ONES && load_lo == HALF_ONES) begin
            type_class = TC_DATA;
        end
        if (graphic_hit) begin
            type_class = TC_GRAPHIC;
        end
    end

endmodule
